[src/multilevel_queue_slot_scheduler_core_defines.svh]
// Assertion macros shared by the scheduler modules.
`ifndef MULTILEVEL_QUEUE_SLOT_SCHEDULER_CORE_DEFINES_SVH
`define MULTILEVEL_QUEUE_SLOT_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MLQS_ASSERT_IMPL(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MLQS_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[src/mlqs_pkg.sv]
// Shared types and codes of the multilevel queue slot scheduler.
package mlqs_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_ENQUEUED = 2'd0;
	localparam status_t ST_GRANTED  = 2'd1;
	localparam status_t ST_NONE     = 2'd2;
	localparam status_t ST_DROPPED  = 2'd3;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam int PID_W  = 8;
	localparam int PLVL_W = 3;
	localparam int GID_W  = 8;
	localparam int GLVL_W = 3;

	// controller -> datapath
	typedef struct packed {
		logic start;      // request beat taken this cycle
		logic deq;        // taken beat is a dequeue
		logic enq_eval;   // apply enqueue to the level record just read
		logic scan_eval;  // examine the level record just read
		logic scan_none;  // last level examined without a grant
		logic load_out;   // move result into the response register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;        // examined level can grant
		logic out_free;   // response register can take a result
	} sts_t;

endpackage

[src/mlqs_ctrl.sv]
// Control state machine: request handshake, level scan count, result hand-off.
`include "multilevel_queue_slot_scheduler_core_defines.svh"

module mlqs_ctrl #(
	parameter int NUM_LEVELS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           opcode,
	output logic           req_stall,
	input  mlqs_pkg::sts_t sts,
	output mlqs_pkg::cmd_t cmd
);

	localparam int LW = $clog2(NUM_LEVELS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ENQ,
		S_SCAN,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [LW-1:0]   cnt_q;
	logic            last;

	assign last      = (cnt_q == LW'(NUM_LEVELS - 1));
	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.start = req_valid;
				cmd.deq   = (opcode == mlqs_pkg::OP_DEQ);
			end
			S_ENQ: begin
				cmd.enq_eval = 1'b1;
			end
			S_SCAN: begin
				cmd.scan_eval = 1'b1;
				cmd.scan_none = !sts.hit && last;
			end
			S_DONE: begin
				cmd.load_out = sts.out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cnt_q   <= '0;
						state_q <= (opcode == mlqs_pkg::OP_DEQ) ? S_SCAN : S_ENQ;
					end
				end
				S_ENQ: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (sts.hit || last) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + LW'(1);
					end
				end
				S_DONE: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	`MLQS_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state_q != S_IDLE, "accepted beat did not start work")
	`MLQS_ASSERT_NEXT(a_scan_steps, state_q == S_SCAN && !sts.hit && !last, state_q == S_SCAN && cnt_q == $past(cnt_q) + LW'(1), "scan did not advance one level")

endmodule

[src/mlqs_dp.sv]
// Datapath: level-state memory, id FIFO memory, current level, result and response registers.
`include "multilevel_queue_slot_scheduler_core_defines.svh"

module mlqs_dp #(
	parameter int NUM_LEVELS  = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [mlqs_pkg::PID_W-1:0]           process_id,
	input  logic [mlqs_pkg::PLVL_W-1:0]          priority_level,
	input  mlqs_pkg::cmd_t                       cmd,
	output mlqs_pkg::sts_t                       sts,
	input  logic                                 rsp_stall,
	output logic                                 rsp_valid,
	output mlqs_pkg::status_t                    status,
	output logic [mlqs_pkg::GID_W-1:0]           granted_id,
	output logic [mlqs_pkg::GLVL_W-1:0]          granted_level
);

	localparam int LW  = $clog2(NUM_LEVELS);
	localparam int DW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int SW  = $clog2(NUM_LEVELS + 1);
	localparam int QN  = NUM_LEVELS * QUEUE_DEPTH;
	localparam int QAW = $clog2(QN);

	typedef struct packed {
		logic [DW-1:0] head;
		logic [CW-1:0] count;
		logic [SW-1:0] slots;
	} rec_t;

	// storage
	rec_t                lvl_mem_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] lvl_vld_q;
	logic [ID_WIDTH-1:0] que_mem_q [QN];

	// read-side and item registers
	rec_t                rd_q;
	logic                rdv_q;
	logic [LW-1:0]       rdlvl_q;
	logic [ID_WIDTH-1:0] qrd_q;
	logic [ID_WIDTH-1:0] pid_q;
	logic                plvl_ok_q;
	logic [LW-1:0]       cur_q;
	mlqs_pkg::status_t   res_status_q;
	logic [LW-1:0]       res_lvl_q;

	// response register
	logic                               rsp_valid_q;
	mlqs_pkg::status_t                  status_q;
	logic [mlqs_pkg::GID_W-1:0]         gid_q;
	logic [mlqs_pkg::GLVL_W-1:0]        glvl_q;

	logic                plvl_ok;
	logic [LW-1:0]       enq_lvl;
	logic [LW-1:0]       nxt_lvl;
	logic [LW-1:0]       rd_addr;
	logic                rd_en;
	logic [SW-1:0]       reload;
	rec_t                eff;
	logic                full;
	logic                drop;
	logic [DW:0]         tsum;
	logic [DW-1:0]       tail;
	logic [DW-1:0]       hnext;
	logic                hit;
	logic                exh;
	logic [SW-1:0]       sdec;
	logic                wr_en;
	rec_t                wr_rec;
	logic                adv;
	logic [QAW-1:0]      qbase;
	logic [QAW-1:0]      q_wr_addr;
	logic [QAW-1:0]      q_rd_addr;

	assign plvl_ok = (32'(priority_level) < 32'(NUM_LEVELS));
	assign enq_lvl = plvl_ok ? LW'(priority_level) : '0;
	assign nxt_lvl = (rdlvl_q == LW'(NUM_LEVELS - 1)) ? '0 : rdlvl_q + LW'(1);
	assign rd_addr = cmd.start ? (cmd.deq ? cur_q : enq_lvl) : nxt_lvl;
	assign rd_en   = cmd.start || cmd.scan_eval;

	// a level never written reads as its reset record
	assign reload = SW'(NUM_LEVELS) - SW'(rdlvl_q);
	always_comb begin
		if (rdv_q) begin
			eff = rd_q;
		end else begin
			eff.head  = '0;
			eff.count = '0;
			eff.slots = reload;
		end
	end

	assign full  = (eff.count == CW'(QUEUE_DEPTH));
	assign drop  = !plvl_ok_q || full;
	assign tsum  = (DW+1)'(eff.head) + (DW+1)'(eff.count);
	assign tail  = (tsum >= (DW+1)'(QUEUE_DEPTH)) ? DW'(tsum - (DW+1)'(QUEUE_DEPTH))
	                                              : DW'(tsum);
	assign hnext = (eff.head == DW'(QUEUE_DEPTH - 1)) ? '0 : eff.head + DW'(1);
	assign hit   = (eff.count != '0) && (eff.slots != '0);
	assign exh   = (eff.slots == '0);
	assign sdec  = eff.slots - SW'(1);

	always_comb begin
		wr_en  = 1'b0;
		wr_rec = eff;
		adv    = 1'b0;
		if (cmd.enq_eval && !drop) begin
			wr_en        = 1'b1;
			wr_rec.count = eff.count + CW'(1);
		end else if (cmd.scan_eval && hit) begin
			wr_en        = 1'b1;
			wr_rec.head  = hnext;
			wr_rec.count = eff.count - CW'(1);
			wr_rec.slots = (sdec == '0) ? reload : sdec;
			adv          = (sdec == '0);
		end else if (cmd.scan_eval && exh) begin
			// slots found spent: reload and move past this level
			wr_en        = 1'b1;
			wr_rec.slots = reload;
			adv          = 1'b1;
		end
	end

	assign qbase     = QAW'(rdlvl_q) * QAW'(QUEUE_DEPTH);
	assign q_wr_addr = qbase + QAW'(tail);
	assign q_rd_addr = qbase + QAW'(eff.head);

	assign sts.hit      = hit;
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q    <= lvl_mem_q[rd_addr];
			rdv_q   <= lvl_vld_q[rd_addr];
			rdlvl_q <= rd_addr;
		end
		if (wr_en) begin
			lvl_mem_q[rdlvl_q] <= wr_rec;
		end
		if (cmd.enq_eval && !drop) begin
			que_mem_q[q_wr_addr] <= pid_q;
		end
		if (cmd.scan_eval && hit) begin
			qrd_q <= que_mem_q[q_rd_addr];
		end
		if (cmd.start) begin
			pid_q     <= ID_WIDTH'(process_id);
			plvl_ok_q <= plvl_ok;
		end
		if (cmd.enq_eval) begin
			res_status_q <= drop ? mlqs_pkg::ST_DROPPED : mlqs_pkg::ST_ENQUEUED;
			res_lvl_q    <= '0;
		end else if (cmd.scan_eval && hit) begin
			res_status_q <= mlqs_pkg::ST_GRANTED;
			res_lvl_q    <= rdlvl_q;
		end else if (cmd.scan_none) begin
			res_status_q <= mlqs_pkg::ST_NONE;
			res_lvl_q    <= '0;
		end
		if (cmd.load_out) begin
			status_q <= res_status_q;
			if (res_status_q == mlqs_pkg::ST_GRANTED) begin
				gid_q  <= mlqs_pkg::GID_W'(qrd_q);
				glvl_q <= mlqs_pkg::GLVL_W'(res_lvl_q);
			end else begin
				gid_q  <= '0;
				glvl_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_vld_q   <= '0;
			cur_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				lvl_vld_q[rdlvl_q] <= 1'b1;
			end
			if (adv) begin
				cur_q <= nxt_lvl;
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign granted_id    = gid_q;
	assign granted_level = glvl_q;

	`MLQS_ASSERT_IMPL(a_zero_unless_granted, rsp_valid_q && status_q != mlqs_pkg::ST_GRANTED, gid_q == '0 && glvl_q == '0, "id or level set on a beat without grant")
	`MLQS_ASSERT_IMPL(a_count_bound, cmd.enq_eval || cmd.scan_eval, eff.count <= CW'(QUEUE_DEPTH), "level count beyond queue depth")
	`MLQS_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !rsp_valid_q || !rsp_stall, "response overwritten while stalled")

endmodule

[src/multilevel_queue_slot_scheduler_core.sv]
// Top level of the multilevel queue slot scheduler: control state machine plus datapath.
// Enqueue: level-state read, S_ENQ updates the level, S_DONE loads the response register.
// Dequeue: S_SCAN visits 1..NUM_LEVELS levels round-robin, one registered level-state
//   read each, then S_DONE loads the response; req_stall is high until that load.
// Reset (arst_n low) empties all levels, reloads slots, points at level 0; no clearing pass.
module multilevel_queue_slot_scheduler_core #(
	parameter int NUM_LEVELS  = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        opcode,
	input  logic [mlqs_pkg::PID_W-1:0]  process_id,
	input  logic [mlqs_pkg::PLVL_W-1:0] priority_level,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [1:0]                  status,
	output logic [mlqs_pkg::GID_W-1:0]  granted_id,
	output logic [mlqs_pkg::GLVL_W-1:0] granted_level
);

	mlqs_pkg::cmd_t cmd;
	mlqs_pkg::sts_t sts;

	mlqs_ctrl #(
		.NUM_LEVELS (NUM_LEVELS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.opcode    (opcode),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mlqs_dp #(
		.NUM_LEVELS  (NUM_LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.process_id     (process_id),
		.priority_level (priority_level),
		.cmd            (cmd),
		.sts            (sts),
		.rsp_stall      (rsp_stall),
		.rsp_valid      (rsp_valid),
		.status         (status),
		.granted_id     (granted_id),
		.granted_level  (granted_level)
	);

endmodule

[tb/tb_multilevel_queue_slot_scheduler_core.sv]
// Self-checking testbench for the multilevel queue slot scheduler core.
`timescale 1ns / 100ps

module tb_multilevel_queue_slot_scheduler_core;

	localparam int NLEV       = 8;
	localparam int DEPTH      = 16;
	localparam int CYCLE_CAP  = 400000;
	localparam int PHASE_BEATS = 475;

	typedef logic [mlqs_pkg::PID_W-1:0]  pid_t;
	typedef logic [mlqs_pkg::PLVL_W-1:0] plvl_t;
	typedef logic [mlqs_pkg::GID_W-1:0]  gid_t;
	typedef logic [mlqs_pkg::GLVL_W-1:0] glvl_t;

	typedef struct packed {
		mlqs_pkg::status_t st;
		gid_t              gid;
		glvl_t             glvl;
	} grant_rsp_t;

	// Tracks the ready queues and the slot budget, and holds the responses still owed.
	class grant_tracker;
		gid_t ids [NLEV][DEPTH];
		int unsigned head [NLEV];
		int unsigned fill [NLEV];
		int unsigned slots [NLEV];
		int unsigned cur_lvl;
		grant_rsp_t owed [$];
		int errors;
		int n_enq, n_grant, n_none, n_drop;

		function new();
			for (int i = 0; i < NLEV; i++) begin
				head[i] = 0;
				fill[i] = 0;
				slots[i] = NLEV - i;
			end
			cur_lvl = 0;
			errors = 0;
			n_enq = 0;
			n_grant = 0;
			n_none = 0;
			n_drop = 0;
		endfunction

		function void refill(int unsigned lvl);
			slots[lvl] = NLEV - lvl;
			cur_lvl = (lvl + 1) % NLEV;
		endfunction

		function grant_rsp_t predict_grant(logic op, pid_t pid, plvl_t lvl);
			grant_rsp_t r;
			int unsigned start;
			int unsigned q;
			r = '{st: mlqs_pkg::ST_NONE, gid: '0, glvl: '0};
			if (op == mlqs_pkg::OP_ENQ) begin
				if (lvl >= NLEV || fill[lvl] >= DEPTH) begin
					r.st = mlqs_pkg::ST_DROPPED;
				end else begin
					ids[lvl][(head[lvl] + fill[lvl]) % DEPTH] = pid;
					fill[lvl]++;
					r.st = mlqs_pkg::ST_ENQUEUED;
				end
			end else begin
				start = cur_lvl % NLEV;
				for (int i = 0; i < NLEV; i++) begin
					q = (start + i) % NLEV;
					if (fill[q] != 0 && slots[q] > 0) begin
						r.gid = ids[q][head[q]];
						r.glvl = glvl_t'(q);
						r.st = mlqs_pkg::ST_GRANTED;
						head[q] = (head[q] + 1) % DEPTH;
						fill[q]--;
						slots[q]--;
						if (slots[q] == 0)
							refill(q);
						break;
					end else if (slots[q] == 0) begin
						refill(q);
					end
				end
			end
			return r;
		endfunction

		function void note_request(logic op, pid_t pid, plvl_t lvl);
			grant_rsp_t r;
			r = predict_grant(op, pid, lvl);
			case (r.st)
				mlqs_pkg::ST_ENQUEUED: n_enq++;
				mlqs_pkg::ST_GRANTED:  n_grant++;
				mlqs_pkg::ST_NONE:     n_none++;
				default:               n_drop++;
			endcase
			owed.push_back(r);
		endfunction

		function void check_response(mlqs_pkg::status_t st, gid_t gid, glvl_t glvl);
			grant_rsp_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: response with none pending: status=%0d id=%0d lvl=%0d",
					$time, st, gid, glvl);
				return;
			end
			want = owed.pop_front();
			if (st !== want.st || gid !== want.gid || glvl !== want.glvl) begin
				errors++;
				$display("%0t: mismatch: expected status=%0d id=%0d lvl=%0d,",
					$time, want.st, want.gid, want.glvl);
				$display("%0t:           got status=%0d id=%0d lvl=%0d",
					$time, st, gid, glvl);
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic                opcode;
	pid_t                process_id;
	plvl_t               priority_level;
	logic                rsp_valid;
	logic                rsp_stall;
	mlqs_pkg::status_t   status;
	gid_t                granted_id;
	glvl_t               granted_level;

	int unsigned send_idle_pct;
	int unsigned rsp_stall_pct;
	int unsigned cycle_cnt = 0;
	grant_tracker board;

	multilevel_queue_slot_scheduler_core #(
		.NUM_LEVELS(NLEV),
		.QUEUE_DEPTH(DEPTH),
		.ID_WIDTH(8)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.process_id(process_id),
		.priority_level(priority_level),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.granted_id(granted_id),
		.granted_level(granted_level)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_CAP) begin
			$display("run stopped at cycle cap, %0d responses outstanding", board.pending());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// response side: sample the beat at the edge, then pick the stall for the next cycle
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				board.check_response(status, granted_id, granted_level);
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	task automatic send_beat(input logic op, input pid_t pid, input plvl_t lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		process_id <= pid;
		priority_level <= lvl;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		board.note_request(op, pid, lvl);
	endtask

	task automatic drain_all();
		req_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// bursts of balanced traffic, level filling and queue draining
	task automatic random_traffic(input int beats);
		int done;
		int burst;
		int unsigned mode;
		int unsigned enq_pct;
		plvl_t hot;
		plvl_t lvl;
		logic op;
		done = 0;
		while (done < beats) begin
			mode = $urandom_range(2);
			burst = $urandom_range(10, 50);
			hot = plvl_t'($urandom_range(NLEV - 1));
			enq_pct = (mode == 0) ? 50 : (mode == 1) ? 85 : 15;
			for (int i = 0; i < burst && done < beats; i++) begin
				op = ($urandom_range(99) < enq_pct) ? mlqs_pkg::OP_ENQ : mlqs_pkg::OP_DEQ;
				if (mode == 1 && $urandom_range(99) < 70)
					lvl = hot;
				else
					lvl = plvl_t'($urandom_range(NLEV - 1));
				send_beat(op, pid_t'($urandom_range(255)), lvl);
				done++;
			end
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		opcode = mlqs_pkg::OP_ENQ;
		process_id = '0;
		priority_level = '0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty scan, id extremes, top and bottom level, full level drop
		send_beat(mlqs_pkg::OP_DEQ, 8'h3C, 3'd2);
		send_beat(mlqs_pkg::OP_ENQ, 8'h00, 3'd0);
		send_beat(mlqs_pkg::OP_ENQ, 8'hFF, 3'd7);
		for (int i = 1; i < DEPTH; i++)
			send_beat(mlqs_pkg::OP_ENQ, pid_t'(i * 17), 3'd7);
		send_beat(mlqs_pkg::OP_ENQ, 8'hAA, 3'd7);
		send_beat(mlqs_pkg::OP_ENQ, 8'h55, 3'd3);
		repeat (4) send_beat(mlqs_pkg::OP_DEQ, 8'hFF, 3'd7);
		drain_all();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_idle_pct = 46; rsp_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct = 46; end
				default: begin send_idle_pct = 24; rsp_stall_pct = 24; end
			endcase
			random_traffic(PHASE_BEATS);
			// hold the request side off until every response is back
			drain_all();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d enqueues, %0d grants, %0d empty scans, %0d drops",
			board.n_enq, board.n_grant, board.n_none, board.n_drop);
		$display("over four idle/stall mixes, %0d mismatches", board.errors);
		if (board.errors == 0 && board.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/mlqs_pkg.sv
src/mlqs_ctrl.sv
src/mlqs_dp.sv
src/multilevel_queue_slot_scheduler_core.sv
tb/tb_multilevel_queue_slot_scheduler_core.sv
